@@ rtl/core/trisss_pkg.sv @@
// ============================================================================
// trisss_pkg - shared constants for the triangle angle solver
// Fixed widths, radian constants in Q2.30 and the CORDIC arctangent steps.
// ============================================================================
package trisss_pkg;

    // Field widths
    localparam int SIDE_W = 16;
    localparam int ANG_W  = 16;

    // Datapath widths: CORDIC words, quotient/root bits, angles in radians
    localparam int CW = 34;
    localparam int QB = 31;
    localparam int AW = 32;

    // Parameter defaults
    localparam int SIDE_BITS_DEF     = 16;
    localparam int ANGLE_FRAC_DEF    = 8;
    localparam int CORDIC_STAGES_DEF = 16;

    // Q2.30 constants
    localparam logic signed [CW-1:0] Q_ONE      = 34'sd1073741824;
    localparam logic signed [CW-1:0] PI_Q       = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q  = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_INV_Q = 34'sd652032874;

    // round(2^24 * 180 / pi)
    localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

    localparam logic [31:0] ATAN_HEAD [10] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149
    };

    // atan(2^-i) in Q2.30, truncated
    function automatic logic signed [CW-1:0] atan_step(input int i);
        logic signed [CW-1:0] v;
        v = '0;
        if (i < 10) begin
            v = $signed({2'b00, ATAN_HEAD[i]});
        end else if (i <= 30) begin
            v = CW'((64'd1 << (30 - i)) - 64'd1);
        end
        return v;
    endfunction

endpackage

@@ rtl/core/trisss_if.sv @@
// ============================================================================
// trisss_if - request and response channels of the triangle angle solver
// Valid/ready channels; a request moves when valid and ready are both high.
// ============================================================================
interface trisss_req_if;
    logic                          valid;
    logic                          ready;
    logic [trisss_pkg::SIDE_W-1:0] side_long;
    logic [trisss_pkg::SIDE_W-1:0] side_mid;
    logic [trisss_pkg::SIDE_W-1:0] side_short;

    modport source (output valid, side_long, side_mid, side_short, input ready);
    modport sink   (input valid, side_long, side_mid, side_short, output ready);
endinterface

interface trisss_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [trisss_pkg::ANG_W-1:0] angle_large;
    logic [trisss_pkg::ANG_W-1:0] angle_middle;
    logic [trisss_pkg::ANG_W-1:0] angle_small;
    logic                         valid_res;

    modport source (output valid, angle_large, angle_middle, angle_small, valid_res,
                    input ready);
    modport sink   (input valid, angle_large, angle_middle, angle_small, valid_res,
                    output ready);
endinterface

@@ rtl/core/trisss_div_cell.sv @@
// ============================================================================
// trisss_div_cell - one restoring division step
// Brings in the next dividend bit, subtracts the divisor when it fits and
// shifts one quotient bit in. A row of these forms the full divider.
// ============================================================================
module trisss_div_cell #(
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [DW-1:0]              i_rem,
    input  logic [trisss_pkg::QB-1:0]  i_num,
    input  logic [trisss_pkg::QB-1:0]  i_quo,
    input  logic [DW-1:0]              i_den,
    input  logic [SW-1:0]              i_sb,
    output logic [DW-1:0]              o_rem,
    output logic [trisss_pkg::QB-1:0]  o_num,
    output logic [trisss_pkg::QB-1:0]  o_quo,
    output logic [DW-1:0]              o_den,
    output logic [SW-1:0]              o_sb
);
    import trisss_pkg::*;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] r_rem;
    logic [QB-1:0] r_num;
    logic [QB-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [SW-1:0] r_sb;

    // trial subtract
    assign w_trial = {i_rem, i_num[QB-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_num <= {i_num[QB-2:0], 1'b0};
            r_quo <= {i_quo[QB-2:0], w_ge};
            r_den <= i_den;
            r_sb  <= i_sb;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_den = r_den;
    assign o_sb  = r_sb;

endmodule

@@ rtl/core/trisss_sqrt_cell.sv @@
// ============================================================================
// trisss_sqrt_cell - one digit step of the integer square root
// Takes the next two radicand bits and decides one root bit.
// ============================================================================
module trisss_sqrt_cell #(
    parameter int SW = 1
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [2*trisss_pkg::QB-1:0]  i_v,
    input  logic [trisss_pkg::QB:0]      i_rem,
    input  logic [trisss_pkg::QB-1:0]    i_root,
    input  logic [SW-1:0]                i_sb,
    output logic [2*trisss_pkg::QB-1:0]  o_v,
    output logic [trisss_pkg::QB:0]      o_rem,
    output logic [trisss_pkg::QB-1:0]    o_root,
    output logic [SW-1:0]                o_sb
);
    import trisss_pkg::*;

    localparam int RW = QB + 1;

    logic [RW+1:0]   w_tmp;
    logic [RW+1:0]   w_trial;
    logic [RW+1:0]   w_diff;
    logic            w_ge;
    logic [2*QB-1:0] r_v;
    logic [RW-1:0]   r_rem;
    logic [QB-1:0]   r_root;
    logic [SW-1:0]   r_sb;

    // remainder against 4*root + 1
    assign w_tmp   = {i_rem, i_v[2*QB-1 -: 2]};
    assign w_trial = (RW+2)'({i_root, 2'b01});
    assign w_diff  = w_tmp - w_trial;
    assign w_ge    = (w_tmp >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= {i_v[2*QB-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[RW-1:0] : w_tmp[RW-1:0];
            r_root <= {i_root[QB-2:0], w_ge};
            r_sb   <= i_sb;
        end
    end

    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_sb   = r_sb;

endmodule

@@ rtl/core/trisss_cordic_cell.sv @@
// ============================================================================
// trisss_cordic_cell - one CORDIC micro-rotation
// Vectoring mode steers by the sign of y, rotation mode by the sign of z.
// Shifts are arithmetic, so they round toward minus infinity.
// ============================================================================
module trisss_cordic_cell #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b1,
    parameter int SW     = 1
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [trisss_pkg::CW-1:0] i_x,
    input  logic signed [trisss_pkg::CW-1:0] i_y,
    input  logic signed [trisss_pkg::CW-1:0] i_z,
    input  logic [SW-1:0]                   i_sb,
    output logic signed [trisss_pkg::CW-1:0] o_x,
    output logic signed [trisss_pkg::CW-1:0] o_y,
    output logic signed [trisss_pkg::CW-1:0] o_z,
    output logic [SW-1:0]                   o_sb
);
    import trisss_pkg::*;

    localparam logic signed [CW-1:0] AT = atan_step(STAGE);

    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic                 w_up;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic [SW-1:0]        r_sb;

    assign w_dx = i_y >>> STAGE;
    assign w_dy = i_x >>> STAGE;
    // up: x grows, y shrinks, z accumulates
    assign w_up = VECTOR ? !i_y[CW-1] : i_z[CW-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= w_up ? i_x + w_dx : i_x - w_dx;
            r_y  <= w_up ? i_y - w_dy : i_y + w_dy;
            r_z  <= w_up ? i_z + AT : i_z - AT;
            r_sb <= i_sb;
        end
    end

    assign o_x  = r_x;
    assign o_y  = r_y;
    assign o_z  = r_z;
    assign o_sb = r_sb;

endmodule

@@ rtl/core/triangle_angles_from_sides.sv @@
// ============================================================================
// triangle_angles_from_sides - SSS triangle solver, fully pipelined
// Law of cosines for the large angle, law of sines for the middle angle,
// the rest of 180 degrees for the small one; degrees out in Q8.8 form by default.
// ============================================================================
//
//  channel  | dir | payload                                       | handshake
//  ---------+-----+-----------------------------------------------+-----------
//  i_req    | in  | side_long, side_mid, side_short (16b each)    | valid/ready
//  o_rsp    | out | angle_large/middle/small (16b), valid_res(1b) | valid/ready
//
//  One request per cycle while o_rsp does not stall; the pipe runs through
//  the four 31-cell divider and square-root rows and the three CORDIC rows
//  of CORDIC_STAGES cells each.
//  Synchronous active-low reset clears only the stage valid bits.
//  A stall on o_rsp freezes the whole pipe; i_req.ready drops only while
//  the output register holds an untaken response.
//
module triangle_angles_from_sides #(
    parameter int SIDE_BITS     = trisss_pkg::SIDE_BITS_DEF,
    parameter int ANGLE_FRAC    = trisss_pkg::ANGLE_FRAC_DEF,
    parameter int CORDIC_STAGES = trisss_pkg::CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    trisss_req_if.sink   i_req,
    trisss_rsp_if.source o_rsp
);
    import trisss_pkg::*;

    localparam int NS = CORDIC_STAGES;
    localparam logic [SIDE_W-1:0] SIDE_MASK = (SIDE_BITS >= SIDE_W) ? {SIDE_W{1'b1}} :
                                              SIDE_W'((32'd1 << SIDE_BITS) - 32'd1);
    localparam int DEG_SH = 54 - ANGLE_FRAC;
    localparam logic [63:0] DEG_HALF = 64'd1 << (DEG_SH - 1);
    localparam int DW1 = 2 * SIDE_W + 1;
    localparam int PW  = SIDE_W + QB;
    // stage positions along the pipe
    localparam int S_RC = 12 + 3 * QB + 2 * NS;
    localparam int L    = 18 + 4 * QB + 3 * NS;

    typedef struct packed {
        logic              ok;
        logic [SIDE_W-1:0] a;
        logic [SIDE_W-1:0] b;
        logic              neg;
    } t_sb_front;

    typedef struct packed {
        t_sb_front     f;
        logic [QB-1:0] t;
    } t_sb_sq1;

    typedef struct packed {
        logic              ok;
        logic [SIDE_W-1:0] a;
        logic [SIDE_W-1:0] b;
        logic [AW-1:0]     big;
    } t_sb_rot;

    typedef struct packed {
        logic          ok;
        logic [AW-1:0] big;
    } t_sb_back;

    typedef struct packed {
        logic     ovf;
        t_sb_back k;
    } t_sb_div2;

    typedef struct packed {
        t_sb_back      k;
        logic [QB-1:0] r;
    } t_sb_sq2;

    localparam int SWF = $bits(t_sb_front);
    localparam int SWQ = $bits(t_sb_sq1);
    localparam int SWR = $bits(t_sb_rot);
    localparam int SWB = $bits(t_sb_back);
    localparam int SWD = $bits(t_sb_div2);
    localparam int SWS = $bits(t_sb_sq2);

    // ------------------------------------------------------------------
    // Flow control: the pipe moves whenever the output can be replaced
    // ------------------------------------------------------------------
    logic         w_adv;
    logic [L-1:0] r_vld;

    assign w_adv       = !r_vld[L-1] || o_rsp.ready;
    assign i_req.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[L-2:0], i_req.valid};
        end
    end

    // ------------------------------------------------------------------
    // Front end: capture, checks, squares, cosine ratio operands
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0]   r0_a, r0_b, r0_c;
    logic                r1_ok;
    logic [SIDE_W-1:0]   r1_a, r1_b;
    logic [2*SIDE_W-1:0] r1_sqa, r1_sqb, r1_sqc, r1_bc;
    t_sb_front           r2_sb;
    logic signed [2*SIDE_W+2:0] r2_num;
    logic [DW1-1:0]      r2_den;
    t_sb_front           r3_sb;
    logic [DW1-1:0]      r3_mag;
    logic [DW1-1:0]      r3_den;
    logic [2*SIDE_W+2:0] w_abs;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_a <= i_req.side_long & SIDE_MASK;
            r0_b <= i_req.side_mid & SIDE_MASK;
            r0_c <= i_req.side_short & SIDE_MASK;
        end
    end

    // zero side or triangle inequality broken
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ok  <= (r0_a != '0) && (r0_b != '0) && (r0_c != '0) &&
                      ({1'b0, r0_a} <= {1'b0, r0_b} + {1'b0, r0_c}) &&
                      ({1'b0, r0_b} <= {1'b0, r0_a} + {1'b0, r0_c}) &&
                      ({1'b0, r0_c} <= {1'b0, r0_a} + {1'b0, r0_b});
            r1_a   <= r0_a;
            r1_b   <= r0_b;
            r1_sqa <= r0_a * r0_a;
            r1_sqb <= r0_b * r0_b;
            r1_sqc <= r0_c * r0_c;
            r1_bc  <= r0_b * r0_c;
        end
    end

    // b^2 + c^2 - a^2 and 2bc
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_num    <= $signed({3'b000, r1_sqb}) + $signed({3'b000, r1_sqc}) -
                         $signed({3'b000, r1_sqa});
            r2_den    <= {r1_bc, 1'b0};
            r2_sb.ok  <= r1_ok;
            r2_sb.a   <= r1_a;
            r2_sb.b   <= r1_b;
            r2_sb.neg <= 1'b0;
        end
    end

    // magnitude clamped to the denominator
    assign w_abs = r2_num[2*SIDE_W+2] ? -r2_num : r2_num;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_mag    <= (w_abs > {2'b00, r2_den}) ? r2_den : w_abs[DW1-1:0];
            r3_den    <= r2_den;
            r3_sb.ok  <= r2_sb.ok;
            r3_sb.a   <= r2_sb.a;
            r3_sb.b   <= r2_sb.b;
            r3_sb.neg <= r2_num[2*SIDE_W+2];
        end
    end

    // ------------------------------------------------------------------
    // Divider row 1: t = mag * 2^30 / den
    // ------------------------------------------------------------------
    logic [DW1-1:0] d1_rem [QB+1];
    logic [QB-1:0]  d1_num [QB+1];
    logic [QB-1:0]  d1_quo [QB+1];
    logic [DW1-1:0] d1_den [QB+1];
    logic [SWF-1:0] d1_sb  [QB+1];

    assign d1_rem[0] = {1'b0, r3_mag[DW1-1:1]};
    assign d1_num[0] = {r3_mag[0], {(QB-1){1'b0}}};
    assign d1_quo[0] = '0;
    assign d1_den[0] = r3_den;
    assign d1_sb[0]  = r3_sb;

    for (genvar k = 0; k < QB; k++) begin : g_div1
        trisss_div_cell #(.DW(DW1), .SW(SWF)) u_cell (
            .i_clk (i_clk), .i_en (w_adv),
            .i_rem (d1_rem[k]),   .i_num (d1_num[k]),   .i_quo (d1_quo[k]),
            .i_den (d1_den[k]),   .i_sb  (d1_sb[k]),
            .o_rem (d1_rem[k+1]), .o_num (d1_num[k+1]), .o_quo (d1_quo[k+1]),
            .o_den (d1_den[k+1]), .o_sb  (d1_sb[k+1])
        );
    end

    // 2^60 - t^2 for the arccosine leg
    logic [2*QB-1:0] r_tt;
    logic [2*QB-1:0] r_v1;
    t_sb_sq1         r_tt_sb;
    t_sb_sq1         r_v1_sb;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tt      <= d1_quo[QB] * d1_quo[QB];
            r_tt_sb.f <= t_sb_front'(d1_sb[QB]);
            r_tt_sb.t <= d1_quo[QB];
            r_v1      <= {2'b01, {(2*QB-2){1'b0}}} - r_tt;
            r_v1_sb   <= r_tt_sb;
        end
    end

    // ------------------------------------------------------------------
    // Square-root row 1
    // ------------------------------------------------------------------
    logic [2*QB-1:0] q1_v    [QB+1];
    logic [QB:0]     q1_rem  [QB+1];
    logic [QB-1:0]   q1_root [QB+1];
    logic [SWQ-1:0]  q1_sb   [QB+1];

    assign q1_v[0]    = r_v1;
    assign q1_rem[0]  = '0;
    assign q1_root[0] = '0;
    assign q1_sb[0]   = r_v1_sb;

    for (genvar k = 0; k < QB; k++) begin : g_sq1
        trisss_sqrt_cell #(.SW(SWQ)) u_cell (
            .i_clk (i_clk), .i_en (w_adv),
            .i_v (q1_v[k]),   .i_rem (q1_rem[k]),   .i_root (q1_root[k]),   .i_sb (q1_sb[k]),
            .o_v (q1_v[k+1]), .o_rem (q1_rem[k+1]), .o_root (q1_root[k+1]), .o_sb (q1_sb[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Vectoring row 1: large angle = atan2(sqrt(1 - t^2), t)
    // ------------------------------------------------------------------
    logic signed [CW-1:0] c1_x [NS+1];
    logic signed [CW-1:0] c1_y [NS+1];
    logic signed [CW-1:0] c1_z [NS+1];
    logic [SWF-1:0]       c1_sb [NS+1];
    t_sb_sq1              w_q1_out;

    assign w_q1_out = t_sb_sq1'(q1_sb[QB]);
    assign c1_x[0]  = $signed({{(CW-QB){1'b0}}, w_q1_out.t});
    assign c1_y[0]  = $signed({{(CW-QB){1'b0}}, q1_root[QB]});
    assign c1_z[0]  = '0;
    assign c1_sb[0] = w_q1_out.f;

    for (genvar k = 0; k < NS; k++) begin : g_vec1
        trisss_cordic_cell #(.STAGE(k), .VECTOR(1'b1), .SW(SWF)) u_cell (
            .i_clk (i_clk), .i_en (w_adv),
            .i_x (c1_x[k]),   .i_y (c1_y[k]),   .i_z (c1_z[k]),   .i_sb (c1_sb[k]),
            .o_x (c1_x[k+1]), .o_y (c1_y[k+1]), .o_z (c1_z[k+1]), .o_sb (c1_sb[k+1])
        );
    end

    // mirror for an obtuse angle, clamp to [0, pi], fold for the sine
    t_sb_front            w_c1_out;
    logic signed [CW-1:0] w_big;
    t_sb_rot              r_big_sb;
    t_sb_rot              r_th_sb;
    logic signed [CW-1:0] r_th;

    assign w_c1_out = t_sb_front'(c1_sb[NS]);
    assign w_big    = w_c1_out.neg ? PI_Q - c1_z[NS] : c1_z[NS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_big_sb.ok  <= w_c1_out.ok;
            r_big_sb.a   <= w_c1_out.a;
            r_big_sb.b   <= w_c1_out.b;
            r_big_sb.big <= w_big[CW-1] ? '0 : (w_big > PI_Q) ? PI_Q[AW-1:0] : w_big[AW-1:0];
            r_th_sb      <= r_big_sb;
            r_th         <= ({2'b00, r_big_sb.big} > HALF_PI_Q) ?
                            PI_Q - $signed({2'b00, r_big_sb.big}) :
                            $signed({2'b00, r_big_sb.big});
        end
    end

    // ------------------------------------------------------------------
    // Rotation row: sine of the large angle
    // ------------------------------------------------------------------
    logic signed [CW-1:0] c2_x [NS+1];
    logic signed [CW-1:0] c2_y [NS+1];
    logic signed [CW-1:0] c2_z [NS+1];
    logic [SWR-1:0]       c2_sb [NS+1];

    assign c2_x[0]  = GAIN_INV_Q;
    assign c2_y[0]  = '0;
    assign c2_z[0]  = r_th;
    assign c2_sb[0] = r_th_sb;

    for (genvar k = 0; k < NS; k++) begin : g_rot
        trisss_cordic_cell #(.STAGE(k), .VECTOR(1'b0), .SW(SWR)) u_cell (
            .i_clk (i_clk), .i_en (w_adv),
            .i_x (c2_x[k]),   .i_y (c2_y[k]),   .i_z (c2_z[k]),   .i_sb (c2_sb[k]),
            .o_x (c2_x[k+1]), .o_y (c2_y[k+1]), .o_z (c2_z[k+1]), .o_sb (c2_sb[k+1])
        );
    end

    // clamp sine, b * sin, overflow test against a * 2^31
    logic [QB-1:0]     r_s;
    t_sb_rot           r_s_sb;
    logic [PW-1:0]     r_prod;
    logic [SIDE_W-1:0] r_prod_a;
    t_sb_back          r_prod_sb;
    logic [PW-1:0]     r_ov_prod;
    logic [SIDE_W-1:0] r_ov_a;
    t_sb_div2          r_ov_sb;
    logic signed [CW-1:0] w_sy;

    assign w_sy = c2_y[NS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s           <= w_sy[CW-1] ? '0 : (w_sy > Q_ONE) ? Q_ONE[QB-1:0] : w_sy[QB-1:0];
            r_s_sb        <= t_sb_rot'(c2_sb[NS]);
            r_prod        <= r_s_sb.b * r_s;
            r_prod_a      <= r_s_sb.a;
            r_prod_sb.ok  <= r_s_sb.ok;
            r_prod_sb.big <= r_s_sb.big;
            r_ov_prod     <= r_prod;
            r_ov_a        <= r_prod_a;
            r_ov_sb.ovf   <= (r_prod[PW-1:QB] >= r_prod_a);
            r_ov_sb.k     <= r_prod_sb;
        end
    end

    // ------------------------------------------------------------------
    // Divider row 2: r = b * sin / a
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] d2_rem [QB+1];
    logic [QB-1:0]     d2_num [QB+1];
    logic [QB-1:0]     d2_quo [QB+1];
    logic [SIDE_W-1:0] d2_den [QB+1];
    logic [SWD-1:0]    d2_sb  [QB+1];

    assign d2_rem[0] = r_ov_prod[PW-1:QB];
    assign d2_num[0] = r_ov_prod[QB-1:0];
    assign d2_quo[0] = '0;
    assign d2_den[0] = r_ov_a;
    assign d2_sb[0]  = r_ov_sb;

    for (genvar k = 0; k < QB; k++) begin : g_div2
        trisss_div_cell #(.DW(SIDE_W), .SW(SWD)) u_cell (
            .i_clk (i_clk), .i_en (w_adv),
            .i_rem (d2_rem[k]),   .i_num (d2_num[k]),   .i_quo (d2_quo[k]),
            .i_den (d2_den[k]),   .i_sb  (d2_sb[k]),
            .o_rem (d2_rem[k+1]), .o_num (d2_num[k+1]), .o_quo (d2_quo[k+1]),
            .o_den (d2_den[k+1]), .o_sb  (d2_sb[k+1])
        );
    end

    // clamp the sine ratio to one, then 2^60 - r^2
    t_sb_div2        w_d2_out;
    logic [QB-1:0]   r_r;
    t_sb_back        r_r_sb;
    logic [2*QB-1:0] r_rr;
    t_sb_sq2         r_rr_sb;
    logic [2*QB-1:0] r_v2;
    t_sb_sq2         r_v2_sb;

    assign w_d2_out = t_sb_div2'(d2_sb[QB]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r        <= (w_d2_out.ovf || (d2_quo[QB] > Q_ONE[QB-1:0])) ?
                          Q_ONE[QB-1:0] : d2_quo[QB];
            r_r_sb     <= w_d2_out.k;
            r_rr       <= r_r * r_r;
            r_rr_sb.k  <= r_r_sb;
            r_rr_sb.r  <= r_r;
            r_v2       <= {2'b01, {(2*QB-2){1'b0}}} - r_rr;
            r_v2_sb    <= r_rr_sb;
        end
    end

    // ------------------------------------------------------------------
    // Square-root row 2
    // ------------------------------------------------------------------
    logic [2*QB-1:0] q2_v    [QB+1];
    logic [QB:0]     q2_rem  [QB+1];
    logic [QB-1:0]   q2_root [QB+1];
    logic [SWS-1:0]  q2_sb   [QB+1];

    assign q2_v[0]    = r_v2;
    assign q2_rem[0]  = '0;
    assign q2_root[0] = '0;
    assign q2_sb[0]   = r_v2_sb;

    for (genvar k = 0; k < QB; k++) begin : g_sq2
        trisss_sqrt_cell #(.SW(SWS)) u_cell (
            .i_clk (i_clk), .i_en (w_adv),
            .i_v (q2_v[k]),   .i_rem (q2_rem[k]),   .i_root (q2_root[k]),   .i_sb (q2_sb[k]),
            .o_v (q2_v[k+1]), .o_rem (q2_rem[k+1]), .o_root (q2_root[k+1]), .o_sb (q2_sb[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Vectoring row 2: middle angle = atan2(r, sqrt(1 - r^2))
    // ------------------------------------------------------------------
    logic signed [CW-1:0] c3_x [NS+1];
    logic signed [CW-1:0] c3_y [NS+1];
    logic signed [CW-1:0] c3_z [NS+1];
    logic [SWB-1:0]       c3_sb [NS+1];
    t_sb_sq2              w_q2_out;

    assign w_q2_out = t_sb_sq2'(q2_sb[QB]);
    assign c3_x[0]  = $signed({{(CW-QB){1'b0}}, q2_root[QB]});
    assign c3_y[0]  = $signed({{(CW-QB){1'b0}}, w_q2_out.r});
    assign c3_z[0]  = '0;
    assign c3_sb[0] = w_q2_out.k;

    for (genvar k = 0; k < NS; k++) begin : g_vec2
        trisss_cordic_cell #(.STAGE(k), .VECTOR(1'b1), .SW(SWB)) u_cell (
            .i_clk (i_clk), .i_en (w_adv),
            .i_x (c3_x[k]),   .i_y (c3_y[k]),   .i_z (c3_z[k]),   .i_sb (c3_sb[k]),
            .o_x (c3_x[k+1]), .o_y (c3_y[k+1]), .o_z (c3_z[k+1]), .o_sb (c3_sb[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Back end: clamp middle angle, small angle, conversion to degrees
    // ------------------------------------------------------------------
    logic signed [CW-1:0] w_mid;
    logic [AW-1:0]        r_mid;
    t_sb_back             r_mid_sb;
    logic signed [CW-1:0] w_small;
    logic [AW-1:0]        r_sm_big, r_sm_mid, r_sm_small;
    logic                 r_sm_ok;
    logic [2*QB-1:0]      r_pl_big, r_pl_mid, r_pl_small;
    logic                 r_pl_ok;
    logic [ANG_W-1:0]     r_o_large, r_o_middle, r_o_small;
    logic                 r_o_ok;

    assign w_mid   = c3_z[NS];
    assign w_small = PI_Q - $signed({2'b00, r_mid_sb.big}) - $signed({2'b00, r_mid});

    // rounded, saturated degree value
    function automatic logic [ANG_W-1:0] to_deg(input logic [2*QB-1:0] p);
        logic [63:0] s;
        s = 64'(p) + DEG_HALF;
        s = s >> DEG_SH;
        return (|s[63:ANG_W]) ? {ANG_W{1'b1}} : s[ANG_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mid      <= w_mid[CW-1] ? '0 : (w_mid > PI_Q) ? PI_Q[AW-1:0] : w_mid[AW-1:0];
            r_mid_sb   <= t_sb_back'(c3_sb[NS]);
            r_sm_big   <= r_mid_sb.big;
            r_sm_mid   <= r_mid;
            r_sm_small <= w_small[CW-1] ? '0 : (w_small > PI_Q) ? PI_Q[AW-1:0] :
                          w_small[AW-1:0];
            r_sm_ok    <= r_mid_sb.ok;
            r_pl_big   <= r_sm_big * DEG_PER_RAD_Q24;
            r_pl_mid   <= r_sm_mid * DEG_PER_RAD_Q24;
            r_pl_small <= r_sm_small * DEG_PER_RAD_Q24;
            r_pl_ok    <= r_sm_ok;
            r_o_large  <= r_pl_ok ? to_deg(r_pl_big) : '0;
            r_o_middle <= r_pl_ok ? to_deg(r_pl_mid) : '0;
            r_o_small  <= r_pl_ok ? to_deg(r_pl_small) : '0;
            r_o_ok     <= r_pl_ok;
        end
    end

    assign o_rsp.valid        = r_vld[L-1];
    assign o_rsp.angle_large  = r_o_large;
    assign o_rsp.angle_middle = r_o_middle;
    assign o_rsp.angle_small  = r_o_small;
    assign o_rsp.valid_res    = r_o_ok;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_bad_tri_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.valid_res) |->
        (o_rsp.angle_large == '0 && o_rsp.angle_middle == '0 && o_rsp.angle_small == '0))
        else $error("invalid triangle with nonzero angles");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("stage valids moved during a stall");

    a_ratio_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_RC-1] |-> ({1'b0, r_r} <= Q_ONE[QB:0]))
        else $error("sine ratio above one");

endmodule
